>>> rtl/tmlos_pkg.sv
// Shared types and constants for the tile map line-of-sight block.
// Used by the controller, the datapath and the top level.
package tmlos_pkg;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MASK = 2'd2;

	localparam logic [6:0]  MAP_WIDTH_RST  = 7'd64;
	localparam logic [6:0]  MAP_HEIGHT_RST = 7'd64;
	localparam logic [31:0] BLOCK_MASK_RST = 32'd13084;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RAY   = 1'b1;

	// input beat, last field in the lowest bits
	typedef struct packed {
		logic signed [7:0] target_y;
		logic signed [7:0] target_x;
		logic [5:0]        origin_y;
		logic [5:0]        origin_x;
		logic [7:0]        tile_value;
		logic [5:0]        write_y;
		logic [5:0]        write_x;
	} in_data_t;

	typedef struct packed {
		logic [3:0] pad;
		logic [7:0] cell_tile;
		logic [5:0] cell_y;
		logic [5:0] cell_x;
	} out_data_t;

	typedef struct packed {
		logic load;
		logic wr_en;
		logic rd_cur;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic origin_in;
		logic last_cell;
		logic out_free;
	} status_t;

endpackage

>>> rtl/tmlos_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tmlos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tmlos_ctrl.sv
// Controller state machine for the line-of-sight block.
// Depends on tmlos_pkg for the command and status structs.
module tmlos_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_tvalid,
	input  logic               op,
	output logic               in_tready,
	input  tmlos_pkg::status_t status,
	output tmlos_pkg::cmd_t    cmd
);
	import tmlos_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CHECK = 3'b010,
		S_TILE  = 3'b100
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		in_tready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) begin
					if (op == OP_RAY) begin
						cmd.load = 1'b1;
						state_nx = S_CHECK;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			S_CHECK: begin
				if (status.origin_in) begin
					cmd.rd_cur = 1'b1;
					state_nx   = S_TILE;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_TILE: begin
				if (status.out_free) begin
					cmd.step = 1'b1;
					if (status.last_cell) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_tile_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TILE) |-> ($past(state_q) == S_CHECK || $past(state_q) == S_TILE))
		else $error("tile state entered without a read");

	a_step_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> status.out_free)
		else $error("step issued while output busy");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load || cmd.wr_en) |-> (state_q == S_IDLE))
		else $error("beat taken while a ray is in flight");

endmodule

>>> rtl/tmlos_dp.sv
// Datapath: config registers, tile RAM, Bresenham walker and output register.
// Depends on tmlos_pkg and tmlos_ram.
module tmlos_dp #(
	parameter int MAP_DIM   = 64,
	parameter int MAX_STEPS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tmlos_pkg::cmd_t                      cmd,
	output tmlos_pkg::status_t                   status,
	input  logic [tmlos_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [tmlos_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tmlos_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [tmlos_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic [tmlos_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	output logic                                 m_axis_tlast
);
	import tmlos_pkg::*;

	localparam int AddrW  = $clog2(MAP_DIM * MAP_DIM);
	localparam int CntW   = $clog2(MAX_STEPS + 1);
	localparam int DimCap = (MAP_DIM < 64) ? MAP_DIM : 64;

	in_data_t d;
	assign d = s_axis_tdata;

	// config
	logic [6:0]  map_width_q, map_height_q;
	logic [31:0] block_mask_q;
	logic [6:0]  w_eff, h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_WIDTH_RST;
			map_height_q <= MAP_HEIGHT_RST;
			block_mask_q <= BLOCK_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_WIDTH:  map_width_q  <= cfg_data[6:0];
				CFG_MAP_HEIGHT: map_height_q <= cfg_data[6:0];
				CFG_BLOCK_MASK: block_mask_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (map_width_q > 7'(DimCap)) ? 7'(DimCap) : map_width_q;
	assign h_eff = (map_height_q > 7'(DimCap)) ? 7'(DimCap) : map_height_q;

	function automatic logic in_map(input logic signed [8:0] xv, input logic signed [8:0] yv,
			input logic [6:0] wv, input logic [6:0] hv);
		return !xv[8] && !yv[8] && (xv[7:0] < {1'b0, wv}) && (yv[7:0] < {1'b0, hv});
	endfunction

	function automatic logic [AddrW-1:0] tile_addr(input logic [5:0] xv, input logic [5:0] yv);
		return AddrW'(yv) * AddrW'(MAP_DIM) + AddrW'(xv);
	endfunction

	// walker
	logic signed [8:0] x_q, y_q, x_nx, y_nx;
	logic signed [9:0] err_q, err_nx;
	logic [8:0]        dx2_q, dy2_q, n_q, n_dec;
	logic              xneg_q, yneg_q, step_x;
	logic [CntW-1:0]   cnt_q, cnt_inc;

	logic signed [8:0] ox9, oy9, tx9, ty9, ddx, ddy;
	logic [7:0]        adx, ady;

	assign ox9 = $signed({3'b000, d.origin_x});
	assign oy9 = $signed({3'b000, d.origin_y});
	assign tx9 = {d.target_x[7], d.target_x};
	assign ty9 = {d.target_y[7], d.target_y};
	assign ddx = tx9 - ox9;
	assign ddy = ty9 - oy9;
	assign adx = ddx[8] ? 8'(-ddx) : ddx[7:0];
	assign ady = ddy[8] ? 8'(-ddy) : ddy[7:0];

	assign step_x = !err_q[9] && (err_q != '0);
	assign x_nx   = step_x ? (xneg_q ? x_q - 9'sd1 : x_q + 9'sd1) : x_q;
	assign y_nx   = step_x ? y_q : (yneg_q ? y_q - 9'sd1 : y_q + 9'sd1);
	assign err_nx = step_x ? err_q - $signed({1'b0, dy2_q}) : err_q + $signed({1'b0, dx2_q});
	assign n_dec  = n_q - 9'd1;
	assign cnt_inc = cnt_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= ox9;
			y_q    <= oy9;
			err_q  <= $signed({2'b00, adx}) - $signed({2'b00, ady});
			dx2_q  <= {adx, 1'b0};
			dy2_q  <= {ady, 1'b0};
			n_q    <= 9'd1 + {1'b0, adx} + {1'b0, ady};
			xneg_q <= !(!ddx[8] && (ddx != '0));
			yneg_q <= !(!ddy[8] && (ddy != '0));
		end else if (cmd.step) begin
			x_q   <= x_nx;
			y_q   <= y_nx;
			err_q <= err_nx;
			n_q   <= n_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_inc;
		end
	end

	// tile store
	logic [AddrW-1:0] waddr, raddr;
	logic             ram_we, ram_re;
	logic [7:0]       tile;

	assign waddr  = tile_addr(d.write_x, d.write_y);
	assign ram_we = cmd.wr_en && (32'(d.write_x) < MAP_DIM) && (32'(d.write_y) < MAP_DIM);

	logic blk, lim, cell_last, next_in;

	assign next_in   = in_map(x_nx, y_nx, w_eff, h_eff);
	assign blk       = (cnt_q != '0) && block_mask_q[tile[4:0]];
	assign lim       = (cnt_inc == CntW'(MAX_STEPS));
	assign cell_last = blk || (n_dec == '0) || lim || !next_in;

	assign ram_re = cmd.rd_cur || (cmd.step && !cell_last);
	assign raddr  = cmd.rd_cur ? tile_addr(x_q[5:0], y_q[5:0]) : tile_addr(x_nx[5:0], y_nx[5:0]);

	tmlos_ram #(
		.WIDTH(8),
		.DEPTH(MAP_DIM * MAP_DIM)
	) u_tiles (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(d.tile_value),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(tile)
	);

	// output register
	logic      out_valid_q;
	out_data_t out_data_q;
	logic      out_blk_q, out_cut_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_data_q.pad       <= '0;
			out_data_q.cell_tile <= tile;
			out_data_q.cell_y    <= y_q[5:0];
			out_data_q.cell_x    <= x_q[5:0];
			out_blk_q            <= blk;
			out_cut_q            <= !blk && lim && (n_dec != '0);
			out_last_q           <= cell_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = {out_cut_q, out_blk_q};
	assign m_axis_tlast  = out_last_q;

	assign status.origin_in = in_map(x_q, y_q, w_eff, h_eff);
	assign status.last_cell = cell_last;
	assign status.out_free  = !out_valid_q || m_axis_tready;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MAX_STEPS))
		else $error("cell count beyond step limit");

	a_blk_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
		else $error("blocking cell not marked last");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !(cmd.rd_cur || cmd.step || cmd.load))
		else $error("tile write during a walk");

	a_read_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !cell_last) |=> in_map(x_q, y_q, w_eff, h_eff))
		else $error("walker moved outside the map while reading");

endmodule

>>> rtl/tile_map_line_of_sight.sv
// Top level of the tile map line-of-sight block.
// Depends on tmlos_pkg, tmlos_ctrl and tmlos_dp (which holds tmlos_ram).
//
// A write beat (tuser = 0) stores one tile byte. A ray beat (tuser = 1) walks a
// 4-connected Bresenham line and sends one output beat per in-map cell; the
// walk is paced by the single read port of the tile RAM, which gives one tile
// per cycle, and waits while the output is stalled. A ray whose origin lies
// outside the map sends nothing. The output register lets the next input beat
// be taken while the final cell still waits. Tiles read before being written
// hold arbitrary values; there is no clearing pass after reset.
module tile_map_line_of_sight #(
	parameter int MAP_DIM   = 64,
	parameter int MAX_STEPS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// write_x, write_y, tile_value, origin_x, origin_y, target_x, target_y
	input  logic [tmlos_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// op
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// cell_x, cell_y, cell_tile, zero pad
	output logic [tmlos_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// blocked, cut_short
	output logic [tmlos_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	output logic                               m_axis_tlast,
	input  logic                               cfg_we,
	input  logic [tmlos_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmlos_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tmlos_pkg::*;

	cmd_t    cmd;
	status_t status;

	tmlos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tvalid(s_axis_tvalid),
		.op       (s_axis_tuser),
		.in_tready(s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tmlos_dp #(
		.MAP_DIM  (MAP_DIM),
		.MAX_STEPS(MAX_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.s_axis_tdata (s_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
